// ===== src/i2c_master_bit_sequencer_assert.svh =====
// Assertion helpers shared by the sequencer modules.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define I2CMBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/i2cmbs_pkg.sv =====
`default_nettype none

package i2cmbs_pkg;

  // command op codes on the input channel
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_SEND_ACK = 3'd4;
  localparam logic [2:0] OP_RECV_ACK = 3'd5;

  typedef enum logic [2:0] {
    K_START,
    K_STOP,
    K_WRITE,
    K_READ,
    K_SEND_ACK,
    K_RECV_ACK
  } kind_t;

  // one queued command
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic [7:0] slave_bits;
    logic       slave_ack;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/i2cmbs_cmd_front.sv =====
`default_nettype none

// Accepts commands and decodes the op; unused op codes are taken and dropped.
module i2cmbs_cmd_front
  import i2cmbs_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_op,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_ack_to_send,
  input  wire logic [7:0] in_slave_bits,
  input  wire logic       in_slave_ack,
  input  wire logic       push_ready,
  output logic            push_valid,
  output cmd_t            push_cmd
);

  logic  op_ok;
  kind_t kind;

  always_comb begin
    op_ok = 1'b1;
    kind  = K_START;
    unique case (in_op)
      OP_START:    kind = K_START;
      OP_STOP:     kind = K_STOP;
      OP_WRITE:    kind = K_WRITE;
      OP_READ:     kind = K_READ;
      OP_SEND_ACK: kind = K_SEND_ACK;
      OP_RECV_ACK: kind = K_RECV_ACK;
      default:     op_ok = 1'b0;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && op_ok;

  always_comb begin
    push_cmd.kind        = kind;
    push_cmd.tx_byte     = in_tx_byte;
    push_cmd.ack_to_send = in_ack_to_send;
    push_cmd.slave_bits  = in_slave_bits;
    push_cmd.slave_ack   = in_slave_ack;
  end

endmodule

`default_nettype wire

// ===== src/i2cmbs_cmd_queue.sv =====
`default_nettype none

`include "i2c_master_bit_sequencer_assert.svh"

// Small command FIFO between decode and slot generation.
module i2cmbs_cmd_queue
  import i2cmbs_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    // count holds when both or neither happen
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `I2CMBS_ASSERT_NOW(a_q_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL,
                     "queue overfilled")
  `I2CMBS_ASSERT_NOW(a_q_pop_empty, clk, rst_n, pop, count_r != '0,
                     "pop from empty queue")
  `I2CMBS_ASSERT_NEXT(a_q_inc, clk, rst_n, push && !pop,
                      count_r == $past(count_r) + 1'b1, "count missed a push")

endmodule

`default_nettype wire

// ===== src/i2cmbs_slot_gen.sv =====
`default_nettype none

`include "i2c_master_bit_sequencer_assert.svh"

// Expands a command into line slots, one per unstalled cycle into the output register.
module i2cmbs_slot_gen
  import i2cmbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic            out_sample_slot,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_received,
  output logic            out_last_slot
);

  logic       busy_r, busy_nxt;
  cmd_t       cmd_r;
  logic [1:0] ph_r, ph_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       scl_r, sda_r;

  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_smp_r, out_ack_r, out_last_r;
  logic [7:0] out_rx_r;

  cmd_t       cur;
  logic       out_free, emit;
  logic       scl_n, sda_n, smp_n, ack_n, last_n;
  logic [7:0] rx_n;

  assign cur      = busy_r ? cmd_r : q_cmd;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (busy_r || q_valid) && out_free;
  assign q_pop    = emit && !busy_r;

  always_comb begin
    scl_n   = scl_r;
    sda_n   = sda_r;
    smp_n   = 1'b0;
    ack_n   = 1'b0;
    last_n  = 1'b0;
    rx_n    = '0;
    ph_nxt  = ph_r + 1'b1;
    bit_nxt = bit_r;
    unique case (cur.kind)
      K_START: begin
        unique case (ph_r)
          2'd0: sda_n = 1'b1;
          2'd1: scl_n = 1'b1;
          2'd2: sda_n = 1'b0;
          2'd3: begin
            scl_n  = 1'b0;
            last_n = 1'b1;
          end
        endcase
      end
      K_STOP: begin
        case (ph_r)
          2'd0: sda_n = 1'b0;
          2'd1: scl_n = 1'b1;
          default: begin
            sda_n  = 1'b1;
            last_n = 1'b1;
          end
        endcase
      end
      K_WRITE: begin
        case (ph_r)
          2'd0: sda_n = cur.tx_byte[3'd7 - bit_r];
          2'd1: scl_n = 1'b1;
          default: begin
            scl_n   = 1'b0;
            ph_nxt  = 2'd0;
            bit_nxt = bit_r + 1'b1;
            last_n  = (bit_r == 3'd7);
          end
        endcase
      end
      K_READ: begin
        // phase 0 releases SDA once, then phases 1..3 repeat per bit
        unique case (ph_r)
          2'd0: sda_n = 1'b1;
          2'd1: scl_n = 1'b1;
          2'd2: smp_n = 1'b1;
          2'd3: begin
            scl_n   = 1'b0;
            ph_nxt  = 2'd1;
            bit_nxt = bit_r + 1'b1;
            last_n  = (bit_r == 3'd7);
            rx_n    = (bit_r == 3'd7) ? cur.slave_bits : 8'd0;
          end
        endcase
      end
      K_SEND_ACK: begin
        case (ph_r)
          2'd0: sda_n = cur.ack_to_send;
          2'd1: scl_n = 1'b1;
          default: begin
            scl_n  = 1'b0;
            last_n = 1'b1;
          end
        endcase
      end
      K_RECV_ACK: begin
        unique case (ph_r)
          2'd0: sda_n = 1'b1;
          2'd1: scl_n = 1'b1;
          2'd2: smp_n = 1'b1;
          2'd3: begin
            scl_n  = 1'b0;
            last_n = 1'b1;
            ack_n  = cur.slave_ack;
          end
        endcase
      end
      default: ;
    endcase
    if (last_n) begin
      ph_nxt  = 2'd0;
      bit_nxt = 3'd0;
    end
    busy_nxt = !last_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ph_r        <= 2'd0;
      bit_r       <= 3'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        busy_r      <= busy_nxt;
        ph_r        <= ph_nxt;
        bit_r       <= bit_nxt;
        scl_r       <= scl_n;
        sda_r       <= sda_n;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (emit) begin
      out_scl_r  <= scl_n;
      out_sda_r  <= sda_n;
      out_smp_r  <= smp_n;
      out_rx_r   <= rx_n;
      out_ack_r  <= ack_n;
      out_last_r <= last_n;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_level    = out_scl_r;
  assign out_sda_level    = out_sda_r;
  assign out_sample_slot  = out_smp_r;
  assign out_rx_byte      = out_rx_r;
  assign out_ack_received = out_ack_r;
  assign out_last_slot    = out_last_r;

  `I2CMBS_ASSERT_NOW(a_smp_scl_high, clk, rst_n, out_valid_r && out_smp_r, out_scl_r, "sample slot with SCL low")
  `I2CMBS_ASSERT_NOW(a_data_on_last, clk, rst_n, out_valid_r && !out_last_r, (out_rx_r == 8'd0) && !out_ack_r, "read data before last slot")
  `I2CMBS_ASSERT_NEXT(a_hold_seq, clk, rst_n, busy_r && !emit, busy_r && $stable(ph_r) && $stable(bit_r), "sequencer moved while stalled")

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
`default_nettype none

// I2C master line sequencer. Each command on the in_ channel (start, stop,
// write byte, read byte, send ack, receive ack) expands into a run of line
// slots on the out_ channel, one slot per transfer: start 4, stop 3, write 24,
// read 25, send ack 3, receive ack 4. A slot gives the open-drain SCL and SDA
// levels (1 = released), flags the slots where SDA is sampled, and flags the
// run's last slot; read byte returns its byte on that slot, receive ack its
// ack level. Bytes go MSB first. Line levels persist across commands and come
// out of reset released. Op codes 6 and 7 are transferred and dropped with no
// slots. Throughput is one slot per cycle while out_ready is high; the slot
// generator walks one slot per clock, unless the output stalls, into a
// single output register. A short command queue sits in front, so new
// commands are transferred while the current one is still being played out.
module i2c_master_bit_sequencer
  import i2cmbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // commands buffered ahead of the slot generator, 2..16
)
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // command channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_op,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_ack_to_send,
  input  wire logic [7:0] in_slave_bits,
  input  wire logic       in_slave_ack,
  // slot channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic            out_sample_slot,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_received,
  output logic            out_last_slot
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // decode: drops unused op codes
  i2cmbs_cmd_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_tx_byte     (in_tx_byte),
    .in_ack_to_send (in_ack_to_send),
    .in_slave_bits  (in_slave_bits),
    .in_slave_ack   (in_slave_ack),
    .push_ready     (push_ready),
    .push_valid     (push_valid),
    .push_cmd       (push_cmd)
  );

  // decouples command intake from slot playback
  i2cmbs_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // slot generation; head command plays out without a load bubble
  i2cmbs_slot_gen u_slots (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_level    (out_scl_level),
    .out_sda_level    (out_sda_level),
    .out_sample_slot  (out_sample_slot),
    .out_rx_byte      (out_rx_byte),
    .out_ack_received (out_ack_received),
    .out_last_slot    (out_last_slot)
  );

endmodule

`default_nettype wire
